[design/crpw_pkg.sv]
package crpw_pkg;

   localparam int COORD_BITS = 16;
   localparam int CALC_BITS = COORD_BITS + 2;
   localparam int CLIP_BITS = 12;
   localparam int SIZE_BITS = 13;
   localparam int PITCH_BITS = 15;
   localparam int PANX_BITS = 12;
   localparam int PANY_BITS = 13;
   localparam int PX_BITS = 13;
   localparam int PY_BITS = 14;
   localparam int PROD_BITS = PY_BITS + PITCH_BITS;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [SIZE_BITS-1:0] SCREEN_MAX = 13'd4096;
   localparam logic [SIZE_BITS-1:0] SCREEN_WIDTH_RESET = 13'd1280;
   localparam logic [SIZE_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd720;
   localparam logic [PITCH_BITS-1:0] LINE_BYTES_RESET = 15'd5120;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [CALC_BITS-1:0] calc_type;

   typedef enum logic {
      REQ_START = 1'b0,
      REQ_PIXEL = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      MODE_ARGB1555 = 3'd0,
      MODE_32BPP = 3'd1,
      MODE_16BPP = 3'd2,
      MODE_8BPP = 3'd3,
      MODE_1BPP = 3'd4
   } pixel_mode_type;

   typedef enum logic [1:0] {
      SIZE_BYTE = 2'd0,
      SIZE_HALF = 2'd1,
      SIZE_WORD = 2'd2
   } write_size_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SCREEN_WIDTH = 3'd0,
      CSR_SCREEN_HEIGHT = 3'd1,
      CSR_LINE_BYTES = 3'd2,
      CSR_PAN_X = 3'd3,
      CSR_PAN_Y = 3'd4,
      CSR_PIXEL_MODE = 3'd5,
      CSR_ROTATE_SWAP = 3'd6
   } csr_index_type;

   localparam logic [2:0] PIXEL_MODE_RESET = MODE_32BPP;

   typedef struct packed {
      logic [SIZE_BITS-1:0] screen_width;
      logic [SIZE_BITS-1:0] screen_height;
      logic [PITCH_BITS-1:0] line_bytes;
      logic [PANX_BITS-1:0] pan_x;
      logic [PANY_BITS-1:0] pan_y;
      logic [2:0] pixel_mode;
      logic rotate_swap;
   } cfg_type;

   typedef struct packed {
      logic req_type;
      logic signed [15:0] corner_x1;
      logic signed [15:0] corner_y1;
      logic signed [15:0] corner_x2;
      logic signed [15:0] corner_y2;
      logic [31:0] source_pixel;
   } req_payload_type;

   typedef struct packed {
      logic write_enable;
      logic [31:0] byte_address;
      logic [31:0] write_data;
      logic [1:0] write_size;
      logic [7:0] bit_mask;
      logic flush_done;
   } rsp_payload_type;

   function automatic logic [SIZE_BITS-1:0] sat_size(input logic [SIZE_BITS-1:0] s);
      logic [SIZE_BITS-1:0] r;
      if (s == '0) begin
         r = SIZE_BITS'(1);
      end else if (s > SCREEN_MAX) begin
         r = SCREEN_MAX;
      end else begin
         r = s;
      end
      return r;
   endfunction

endpackage

[design/clipped_rect_pixel_writer_top.sv]
// a result reaches rsp_ through two registers: the input register and then the result register
// throughput: one item per cycle while rsp_stall is low; start and pixel items take the same single pass
// the cycle is set by one 14x15 row multiply and add between the two registers
// items with no result (accepted start, clipped pixel, idle pixel) leave no bubble on rsp_
// reset (synchronous, active high) empties both registers, drops any rectangle, reloads csr defaults
module clipped_rect_pixel_writer_top (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input crpw_pkg::req_payload_type req_payload,
   output logic rsp_valid,
   input logic rsp_stall,
   output crpw_pkg::rsp_payload_type rsp_payload,
   input logic csr_valid,
   output logic csr_ready,
   input logic [crpw_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [crpw_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   crpw_pkg::cfg_type cfg;
   crpw_pkg::req_payload_type item;
   logic item_valid;
   logic item_take;

   crpw_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cfg(cfg)
   );

   crpw_in_stage u_in_stage (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .item_valid(item_valid),
      .item(item),
      .item_take(item_take)
   );

   crpw_engine u_engine (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .item_valid(item_valid),
      .item(item),
      .item_take(item_take),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule

[design/crpw_csr.sv]
module crpw_csr (
   input logic clock,
   input logic reset,
   input logic csr_valid,
   output logic csr_ready,
   input logic [crpw_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [crpw_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output crpw_pkg::cfg_type cfg
);

   crpw_pkg::cfg_type cfg_ff;
   crpw_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            crpw_pkg::CSR_SCREEN_WIDTH: begin
               cfg_in.screen_width = csr_wdata[crpw_pkg::SIZE_BITS-1:0];
            end
            crpw_pkg::CSR_SCREEN_HEIGHT: begin
               cfg_in.screen_height = csr_wdata[crpw_pkg::SIZE_BITS-1:0];
            end
            crpw_pkg::CSR_LINE_BYTES: begin
               cfg_in.line_bytes = csr_wdata[crpw_pkg::PITCH_BITS-1:0];
            end
            crpw_pkg::CSR_PAN_X: begin
               cfg_in.pan_x = csr_wdata[crpw_pkg::PANX_BITS-1:0];
            end
            crpw_pkg::CSR_PAN_Y: begin
               cfg_in.pan_y = csr_wdata[crpw_pkg::PANY_BITS-1:0];
            end
            crpw_pkg::CSR_PIXEL_MODE: begin
               cfg_in.pixel_mode = csr_wdata[2:0];
            end
            crpw_pkg::CSR_ROTATE_SWAP: begin
               cfg_in.rotate_swap = csr_wdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width <= crpw_pkg::SCREEN_WIDTH_RESET;
         cfg_ff.screen_height <= crpw_pkg::SCREEN_HEIGHT_RESET;
         cfg_ff.line_bytes <= crpw_pkg::LINE_BYTES_RESET;
         cfg_ff.pan_x <= '0;
         cfg_ff.pan_y <= '0;
         cfg_ff.pixel_mode <= crpw_pkg::PIXEL_MODE_RESET;
         cfg_ff.rotate_swap <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[design/crpw_in_stage.sv]
module crpw_in_stage (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input crpw_pkg::req_payload_type req_payload,
   output logic item_valid,
   output crpw_pkg::req_payload_type item,
   input logic item_take
);

   logic valid_ff;
   logic valid_in;
   crpw_pkg::req_payload_type item_ff;
   logic accept;

   assign req_stall = valid_ff && !item_take;
   assign accept = req_valid && !req_stall;
   assign item_valid = valid_ff;
   assign item = item_ff;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (item_take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_payload;
      end
   end

endmodule

[design/crpw_engine.sv]
module crpw_engine (
   input logic clock,
   input logic reset,
   input crpw_pkg::cfg_type cfg,
   input logic item_valid,
   input crpw_pkg::req_payload_type item,
   output logic item_take,
   output logic rsp_valid,
   input logic rsp_stall,
   output crpw_pkg::rsp_payload_type rsp_payload
);

   // rectangle state
   logic rect_active_ff, rect_active_in;
   crpw_pkg::coord_type rect_left_ff, rect_left_in;
   crpw_pkg::coord_type rect_right_ff, rect_right_in;
   crpw_pkg::coord_type rect_bottom_ff, rect_bottom_in;
   crpw_pkg::coord_type cur_x_ff, cur_x_in;
   crpw_pkg::coord_type cur_y_ff, cur_y_in;
   logic [crpw_pkg::CLIP_BITS-1:0] clip_x1_ff, clip_x1_in;
   logic [crpw_pkg::CLIP_BITS-1:0] clip_x2_ff, clip_x2_in;
   logic [crpw_pkg::CLIP_BITS-1:0] clip_y1_ff, clip_y1_in;
   logic [crpw_pkg::CLIP_BITS-1:0] clip_y2_ff, clip_y2_in;

   logic out_valid_ff, out_valid_in;
   crpw_pkg::rsp_payload_type out_ff;

   logic [crpw_pkg::SIZE_BITS-1:0] scr_w, scr_h, lim_x, lim_y;
   crpw_pkg::coord_type c_x1, c_y1, c_x2, c_y2;
   crpw_pkg::calc_type x1, y1, x2, y2, lim_x_c, lim_y_c, w_c, h_c;
   crpw_pkg::calc_type ax1, ay1, ax2, ay2;
   crpw_pkg::calc_type x, y;
   logic reject, in_clip, last;

   logic [crpw_pkg::PX_BITS-1:0] px;
   logic [crpw_pkg::PY_BITS-1:0] py;
   logic [crpw_pkg::PITCH_BITS-1:0] mul_b;
   logic [crpw_pkg::PROD_BITS-1:0] prod;
   logic [31:0] px32, prod32, loc;
   logic [31:0] p;

   logic mode_ok;
   logic [31:0] w_addr, w_data;
   logic [1:0] w_size;
   logic [7:0] w_mask;

   logic has_result;
   crpw_pkg::rsp_payload_type res;
   crpw_pkg::rsp_payload_type no_write;
   logic step;

   assign item_take = item_valid && (!out_valid_ff || !rsp_stall);
   assign step = item_take;
   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_ff;

   // start item: bound check and clip
   assign scr_w = crpw_pkg::sat_size(cfg.screen_width);
   assign scr_h = crpw_pkg::sat_size(cfg.screen_height);
   assign lim_x = cfg.rotate_swap ? scr_h : scr_w;
   assign lim_y = cfg.rotate_swap ? scr_w : scr_h;

   assign c_x1 = item.corner_x1[crpw_pkg::COORD_BITS-1:0];
   assign c_y1 = item.corner_y1[crpw_pkg::COORD_BITS-1:0];
   assign c_x2 = item.corner_x2[crpw_pkg::COORD_BITS-1:0];
   assign c_y2 = item.corner_y2[crpw_pkg::COORD_BITS-1:0];
   assign x1 = crpw_pkg::calc_type'(c_x1);
   assign y1 = crpw_pkg::calc_type'(c_y1);
   assign x2 = crpw_pkg::calc_type'(c_x2);
   assign y2 = crpw_pkg::calc_type'(c_y2);

   assign lim_x_c = crpw_pkg::calc_type'({1'b0, lim_x});
   assign lim_y_c = crpw_pkg::calc_type'({1'b0, lim_y});
   assign w_c = crpw_pkg::calc_type'({1'b0, scr_w});
   assign h_c = crpw_pkg::calc_type'({1'b0, scr_h});

   assign reject = (x2 < 0) || (y2 < 0) || (x1 >= lim_x_c) || (y1 >= lim_y_c)
                   || (x1 > x2) || (y1 > y2);

   assign ax1 = (x1 < 0) ? '0 : x1;
   assign ay1 = (y1 < 0) ? '0 : y1;
   assign ax2 = (x2 >= w_c) ? crpw_pkg::calc_type'(w_c - crpw_pkg::calc_type'(1)) : x2;
   assign ay2 = (y2 >= h_c) ? crpw_pkg::calc_type'(h_c - crpw_pkg::calc_type'(1)) : y2;

   // pixel item: clip test and address
   assign x = crpw_pkg::calc_type'(cur_x_ff);
   assign y = crpw_pkg::calc_type'(cur_y_ff);
   assign last = (cur_x_ff == rect_right_ff) && (cur_y_ff == rect_bottom_ff);
   assign in_clip = (x >= crpw_pkg::calc_type'({1'b0, clip_x1_ff}))
                    && (x <= crpw_pkg::calc_type'({1'b0, clip_x2_ff}))
                    && (y >= crpw_pkg::calc_type'({1'b0, clip_y1_ff}))
                    && (y <= crpw_pkg::calc_type'({1'b0, clip_y2_ff}));

   assign px = crpw_pkg::PX_BITS'(cur_x_ff[crpw_pkg::CLIP_BITS-1:0])
               + crpw_pkg::PX_BITS'(cfg.pan_x);
   assign py = crpw_pkg::PY_BITS'(cur_y_ff[crpw_pkg::CLIP_BITS-1:0])
               + crpw_pkg::PY_BITS'(cfg.pan_y);
   assign mul_b = (cfg.pixel_mode == crpw_pkg::MODE_1BPP)
                  ? crpw_pkg::PITCH_BITS'(scr_w) : cfg.line_bytes;
   assign prod = crpw_pkg::PROD_BITS'(py) * crpw_pkg::PROD_BITS'(mul_b);
   assign px32 = 32'(px);
   assign prod32 = 32'(prod);
   assign loc = px32 + prod32;
   assign p = item.source_pixel;

   always_comb begin
      mode_ok = 1'b1;
      w_addr = '0;
      w_data = '0;
      w_size = crpw_pkg::SIZE_BYTE;
      w_mask = 8'hff;
      case (cfg.pixel_mode)
         crpw_pkg::MODE_ARGB1555: begin
            w_addr = (px32 << 1) + (prod32 & ~32'd1);
            w_data = {16'd0, |p[31:24], p[23:19], p[15:11], p[7:3]};
            w_size = crpw_pkg::SIZE_HALF;
         end
         crpw_pkg::MODE_32BPP: begin
            w_addr = (px32 << 2) + (prod32 & ~32'd3);
            w_data = p;
            w_size = crpw_pkg::SIZE_WORD;
         end
         crpw_pkg::MODE_16BPP: begin
            w_addr = (px32 << 1) + (prod32 & ~32'd1);
            w_data = {16'd0, p[15:0]};
            w_size = crpw_pkg::SIZE_HALF;
         end
         crpw_pkg::MODE_8BPP: begin
            w_addr = loc;
            w_data = {24'd0, p[7:0]};
         end
         crpw_pkg::MODE_1BPP: begin
            w_addr = loc >> 3;
            w_data = 32'(p[0]) << loc[2:0];
            w_mask = 8'd1 << loc[2:0];
         end
         default: begin
            mode_ok = 1'b0;
         end
      endcase
   end

   // result and state update
   always_comb begin
      no_write = '0;
      no_write.flush_done = 1'b1;

      has_result = 1'b0;
      res = no_write;

      rect_active_in = rect_active_ff;
      rect_left_in = rect_left_ff;
      rect_right_in = rect_right_ff;
      rect_bottom_in = rect_bottom_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      clip_x1_in = clip_x1_ff;
      clip_x2_in = clip_x2_ff;
      clip_y1_in = clip_y1_ff;
      clip_y2_in = clip_y2_ff;

      if (item.req_type == crpw_pkg::REQ_START) begin
         rect_active_in = !reject;
         has_result = reject;
         if (!reject) begin
            rect_left_in = c_x1;
            rect_right_in = c_x2;
            rect_bottom_in = c_y2;
            cur_x_in = c_x1;
            cur_y_in = c_y1;
            clip_x1_in = ax1[crpw_pkg::CLIP_BITS-1:0];
            clip_x2_in = ax2[crpw_pkg::CLIP_BITS-1:0];
            clip_y1_in = ay1[crpw_pkg::CLIP_BITS-1:0];
            clip_y2_in = ay2[crpw_pkg::CLIP_BITS-1:0];
         end
      end else if (rect_active_ff) begin
         if (cur_x_ff == rect_right_ff) begin
            cur_x_in = rect_left_ff;
            cur_y_in = crpw_pkg::coord_type'(cur_y_ff + crpw_pkg::coord_type'(1));
         end else begin
            cur_x_in = crpw_pkg::coord_type'(cur_x_ff + crpw_pkg::coord_type'(1));
         end
         if (last) begin
            rect_active_in = 1'b0;
         end
         if (in_clip && mode_ok) begin
            has_result = 1'b1;
            res.write_enable = 1'b1;
            res.byte_address = w_addr;
            res.write_data = w_data;
            res.write_size = w_size;
            res.bit_mask = w_mask;
            res.flush_done = last;
         end else begin
            has_result = last;
         end
      end

      if (!out_valid_ff || !rsp_stall) begin
         out_valid_in = item_valid && has_result;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_active_ff <= 1'b0;
         rect_left_ff <= '0;
         rect_right_ff <= '0;
         rect_bottom_ff <= '0;
         cur_x_ff <= '0;
         cur_y_ff <= '0;
         clip_x1_ff <= '0;
         clip_x2_ff <= '0;
         clip_y1_ff <= '0;
         clip_y2_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (step) begin
            rect_active_ff <= rect_active_in;
            rect_left_ff <= rect_left_in;
            rect_right_ff <= rect_right_in;
            rect_bottom_ff <= rect_bottom_in;
            cur_x_ff <= cur_x_in;
            cur_y_ff <= cur_y_in;
            clip_x1_ff <= clip_x1_in;
            clip_x2_ff <= clip_x2_in;
            clip_y1_ff <= clip_y1_in;
            clip_y2_ff <= clip_y2_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && has_result) begin
         out_ff <= res;
      end
   end

   a_nowrite_is_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.write_enable |-> out_ff.flush_done
         && out_ff.byte_address == '0 && out_ff.bit_mask == '0)
      else $error("result without write is not a bare done");

   a_cursor_in_rect: assert property (@(posedge clock) disable iff (reset)
      rect_active_ff |-> cur_x_ff >= rect_left_ff && cur_x_ff <= rect_right_ff
         && cur_y_ff <= rect_bottom_ff)
      else $error("cursor left the active rectangle");

   a_mask_shape: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.write_enable |-> $onehot(out_ff.bit_mask)
         || out_ff.bit_mask == 8'hff)
      else $error("bit mask neither full nor single bit");

   a_word_aligned: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.write_enable && out_ff.write_size == crpw_pkg::SIZE_WORD
         |-> out_ff.byte_address[1:0] == 2'b00)
      else $error("word write not aligned");

   a_half_aligned: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.write_enable && out_ff.write_size == crpw_pkg::SIZE_HALF
         |-> out_ff.byte_address[0] == 1'b0)
      else $error("halfword write not aligned");

endmodule

[dv/tb_clipped_rect_pixel_writer_top.sv]
`timescale 1ns / 100ps

module tb_clipped_rect_pixel_writer_top;

   localparam int CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   crpw_pkg::req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   crpw_pkg::rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [crpw_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [crpw_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   // shadow registers
   logic [12:0] cfg_width = 13'd1280;
   logic [12:0] cfg_height = 13'd720;
   logic [14:0] cfg_pitch = 15'd5120;
   logic [11:0] cfg_pan_x = '0;
   logic [12:0] cfg_pan_y = '0;
   logic [2:0] cfg_mode = 3'(crpw_pkg::MODE_32BPP);
   logic cfg_rotate = 1'b0;

   // rectangle walk state
   int rect_x1 = 0;
   int rect_x2 = 0;
   int rect_y2 = 0;
   int clip_x1 = 0;
   int clip_x2 = 0;
   int clip_y1 = 0;
   int clip_y2 = 0;
   int next_x = 0;
   int next_y = 0;
   bit rect_live = 1'b0;

   crpw_pkg::rsp_payload_type expected_writes[$];

   int error_count = 0;
   int cycle_count = 0;
   int items_taken = 0;
   int beats_seen = 0;
   int csr_writes = 0;
   int stall_left = 0;
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;

   clipped_rect_pixel_writer_top u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int sat_dim(logic [12:0] s);
      if (s == 13'd0) return 1;
      if (s > 13'd4096) return 4096;
      return int'(s);
   endfunction

   function automatic void apply_csr(crpw_pkg::csr_index_type idx, logic [15:0] value);
      case (idx)
         crpw_pkg::CSR_SCREEN_WIDTH: cfg_width = value[12:0];
         crpw_pkg::CSR_SCREEN_HEIGHT: cfg_height = value[12:0];
         crpw_pkg::CSR_LINE_BYTES: cfg_pitch = value[14:0];
         crpw_pkg::CSR_PAN_X: cfg_pan_x = value[11:0];
         crpw_pkg::CSR_PAN_Y: cfg_pan_y = value[12:0];
         crpw_pkg::CSR_PIXEL_MODE: cfg_mode = value[2:0];
         crpw_pkg::CSR_ROTATE_SWAP: cfg_rotate = value[0];
         default: ;
      endcase
   endfunction

   function automatic void predict_writer(crpw_pkg::req_payload_type item);
      int w, h, xl, yl, x1, y1, x2, y2, x, y;
      bit last, in_clip;
      longint unsigned px, py, row, loc;
      logic [31:0] p;
      crpw_pkg::rsp_payload_type beat;
      w = sat_dim(cfg_width);
      h = sat_dim(cfg_height);
      beat = '0;
      p = item.source_pixel;
      if (item.req_type == crpw_pkg::REQ_START) begin
         x1 = $signed(item.corner_x1);
         y1 = $signed(item.corner_y1);
         x2 = $signed(item.corner_x2);
         y2 = $signed(item.corner_y2);
         xl = cfg_rotate ? h : w;
         yl = cfg_rotate ? w : h;
         rect_live = 1'b0;
         if (x2 < 0 || y2 < 0 || x1 > xl - 1 || y1 > yl - 1 || x1 > x2 || y1 > y2) begin
            beat.flush_done = 1'b1;
            expected_writes.push_back(beat);
         end else begin
            clip_x1 = (x1 < 0 ? 0 : x1) & 'hFFF;
            clip_x2 = (x2 > w - 1 ? w - 1 : x2) & 'hFFF;
            clip_y1 = (y1 < 0 ? 0 : y1) & 'hFFF;
            clip_y2 = (y2 > h - 1 ? h - 1 : y2) & 'hFFF;
            rect_x1 = x1;
            rect_x2 = x2;
            rect_y2 = y2;
            next_x = x1;
            next_y = y1;
            rect_live = 1'b1;
         end
      end else if (rect_live) begin
         x = next_x;
         y = next_y;
         last = (x == rect_x2) && (y == rect_y2);
         in_clip = x >= clip_x1 && x <= clip_x2 && y >= clip_y1 && y <= clip_y2;
         if (x == rect_x2) begin
            next_x = rect_x1;
            next_y = y + 1;
         end else begin
            next_x = x + 1;
         end
         if (last) rect_live = 1'b0;
         if (in_clip && cfg_mode <= 3'(crpw_pkg::MODE_1BPP)) begin
            px = longint'(x) + cfg_pan_x;
            py = longint'(y) + cfg_pan_y;
            row = py * cfg_pitch;
            beat.write_enable = 1'b1;
            beat.bit_mask = 8'hFF;
            beat.flush_done = last;
            case (cfg_mode)
               crpw_pkg::MODE_ARGB1555: begin
                  beat.write_data = {16'd0, p[31:24] != 8'd0, p[23:19], p[15:11], p[7:3]};
                  beat.byte_address = 32'(2 * px + (row & ~64'd1));
                  beat.write_size = crpw_pkg::SIZE_HALF;
               end
               crpw_pkg::MODE_32BPP: begin
                  beat.write_data = p;
                  beat.byte_address = 32'(4 * px + (row & ~64'd3));
                  beat.write_size = crpw_pkg::SIZE_WORD;
               end
               crpw_pkg::MODE_16BPP: begin
                  beat.write_data = {16'd0, p[15:0]};
                  beat.byte_address = 32'(2 * px + (row & ~64'd1));
                  beat.write_size = crpw_pkg::SIZE_HALF;
               end
               crpw_pkg::MODE_8BPP: begin
                  beat.write_data = {24'd0, p[7:0]};
                  beat.byte_address = 32'(px + row);
                  beat.write_size = crpw_pkg::SIZE_BYTE;
               end
               default: begin
                  loc = px + py * longint'(w);
                  beat.byte_address = 32'(loc >> 3);
                  beat.bit_mask = 8'd1 << loc[2:0];
                  beat.write_data = 32'(p[0]) << loc[2:0];
                  beat.write_size = crpw_pkg::SIZE_BYTE;
               end
            endcase
            expected_writes.push_back(beat);
         end else if (last) begin
            beat.flush_done = 1'b1;
            expected_writes.push_back(beat);
         end
      end
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      if (error_count <= 100) begin
         $display("%0t MISMATCH %s got %h want %h", $time, what, got, want);
      end
   endtask

   task automatic send_item(crpw_pkg::req_payload_type item);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (item.req_type == crpw_pkg::REQ_START || rect_live) items_taken++;
      predict_writer(item);
   endtask

   task automatic send_start(int x1, int y1, int x2, int y2);
      crpw_pkg::req_payload_type item;
      item.req_type = crpw_pkg::REQ_START;
      item.corner_x1 = 16'(x1);
      item.corner_y1 = 16'(y1);
      item.corner_x2 = 16'(x2);
      item.corner_y2 = 16'(y2);
      item.source_pixel = $urandom;
      send_item(item);
   endtask

   task automatic send_pixel(logic [31:0] p);
      crpw_pkg::req_payload_type item;
      item.req_type = crpw_pkg::REQ_PIXEL;
      item.corner_x1 = 16'($urandom);
      item.corner_y1 = 16'($urandom);
      item.corner_x2 = 16'($urandom);
      item.corner_y2 = 16'($urandom);
      item.source_pixel = p;
      send_item(item);
   endtask

   task automatic send_rect(int x1, int y1, int x2, int y2);
      send_start(x1, y1, x2, y2);
      while (rect_live) send_pixel($urandom);
   endtask

   // close any open rectangle, drain, then let the pipeline empty
   task automatic settle();
      if (rect_live) send_start(1, 0, 0, 0);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_writes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(crpw_pkg::csr_index_type idx, logic [15:0] value);
      settle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, value);
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_dim();
      case ($urandom_range(0, 6))
         0: return 16'd1;
         1: return 16'd4096;
         2: return 16'd0;
         3: return 16'h1FFF;
         4: return 16'($urandom);
         default: return 16'($urandom_range(2, 48));
      endcase
   endfunction

   function automatic int near_edge(int lim);
      case ($urandom_range(0, 3))
         0: return int'($urandom_range(0, 6)) - 3;
         1: return lim - 3 + int'($urandom_range(0, 6));
         default: return int'($urandom_range(0, lim - 1));
      endcase
   endfunction

   task automatic test_pixel_modes();
      int m;
      for (m = 0; m < 6; m++) begin
         write_csr(crpw_pkg::CSR_PIXEL_MODE, 16'(m));
         send_start(3, 2, 3, 2);
         send_pixel(m[0] ? 32'hFFFF_FFFF : 32'h0000_0001);
      end
      write_csr(crpw_pkg::CSR_PIXEL_MODE, 16'(crpw_pkg::MODE_32BPP));
   endtask

   task automatic test_reject_cases();
      send_start(-32768, -32768, -1, 100);
      send_start(0, -5, 5, -1);
      send_start(32767, 32767, 32767, 32767);
      send_start(5, 0, 4, 0);
      send_start(0, 5, 0, 4);
   endtask

   task automatic test_rotated_clip();
      write_csr(crpw_pkg::CSR_SCREEN_WIDTH, 16'd8);
      write_csr(crpw_pkg::CSR_SCREEN_HEIGHT, 16'd16);
      write_csr(crpw_pkg::CSR_ROTATE_SWAP, 16'd1);
      // x passes the swapped limit but lies right of the screen: empty clip
      send_rect(10, 0, 11, 0);
      send_start(0, 10, 0, 10);
      write_csr(crpw_pkg::CSR_ROTATE_SWAP, 16'd0);
   endtask

   task automatic test_abandoned_rect();
      send_pixel($urandom);
      send_start(-32768, -32768, 32767, 32767);
      send_pixel($urandom);
      send_rect(6, 15, 9, 15);
   endtask

   task automatic test_random_traffic();
      int phase, kind, x1, y1, x2, y2, xl, yl, start_count;
      logic [15:0] wd, ht, lb, panx, pany, md;
      logic rot;
      for (phase = 0; phase < 10; phase++) begin
         req_burst = (phase % 3 == 2);
         rsp_burst = (phase % 4 == 3);
         if (phase == 0) begin
            wd = 16'd1;
            ht = 16'd1;
            lb = 16'd1;
            panx = 16'd0;
            pany = 16'd0;
            md = 16'(crpw_pkg::MODE_ARGB1555);
            rot = 1'b0;
         end else if (phase == 1) begin
            wd = 16'h1FFF;
            ht = 16'd4096;
            lb = 16'h7FFF;
            panx = 16'd4095;
            pany = 16'd8191;
            md = 16'(crpw_pkg::MODE_1BPP);
            rot = 1'b1;
         end else begin
            wd = pick_dim();
            ht = pick_dim();
            case ($urandom_range(0, 4))
               0: lb = 16'd1;
               1: lb = 16'd16384;
               2: lb = 16'($urandom);
               default: lb = 16'(4 * $urandom_range(1, 1024));
            endcase
            case ($urandom_range(0, 2))
               0: panx = 16'd0;
               1: panx = 16'd4095;
               default: panx = 16'($urandom);
            endcase
            case ($urandom_range(0, 2))
               0: pany = 16'd0;
               1: pany = 16'd8191;
               default: pany = 16'($urandom);
            endcase
            md = 16'((phase - 2) % 8);
            rot = 1'($urandom_range(0, 1));
         end
         write_csr(crpw_pkg::CSR_SCREEN_WIDTH, wd);
         write_csr(crpw_pkg::CSR_SCREEN_HEIGHT, ht);
         write_csr(crpw_pkg::CSR_LINE_BYTES, lb);
         write_csr(crpw_pkg::CSR_PAN_X, panx);
         write_csr(crpw_pkg::CSR_PAN_Y, pany);
         write_csr(crpw_pkg::CSR_PIXEL_MODE, md);
         write_csr(crpw_pkg::CSR_ROTATE_SWAP, {15'd0, rot});
         xl = cfg_rotate ? sat_dim(cfg_height) : sat_dim(cfg_width);
         yl = cfg_rotate ? sat_dim(cfg_width) : sat_dim(cfg_height);
         start_count = items_taken;
         while (items_taken - start_count < 60) begin
            kind = $urandom_range(0, 9);
            x1 = near_edge(xl);
            y1 = near_edge(yl);
            x2 = x1 + int'($urandom_range(0, 4)) - int'($urandom_range(0, 9) == 0);
            y2 = y1 + int'($urandom_range(0, 4)) - int'($urandom_range(0, 9) == 0);
            case (kind)
               7: begin
                  // cut short, the next start drops it
                  send_start(x1, y1, x2, y2);
                  repeat ($urandom_range(0, 3)) send_pixel($urandom);
               end
               8: begin
                  repeat ($urandom_range(1, 2)) send_pixel($urandom);
               end
               9: begin
                  send_start(int'($urandom_range(0, 65535)) - 32768,
                             int'($urandom_range(0, 65535)) - 32768,
                             int'($urandom_range(0, 65535)) - 32768,
                             int'($urandom_range(0, 65535)) - 32768);
                  repeat ($urandom_range(0, 2)) send_pixel($urandom);
               end
               default: send_rect(x1, y1, x2, y2);
            endcase
         end
      end
      req_burst = 1'b0;
      rsp_burst = 1'b0;
   endtask

   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         if (rsp_valid) stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      crpw_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_seen++;
         stall_left = rsp_burst ? 0 : $urandom_range(0, 6);
         if (expected_writes.size() == 0) begin
            report_mismatch("beat with nothing pending", rsp_payload.byte_address, 32'd0);
         end else begin
            want = expected_writes.pop_front();
            if (rsp_payload.write_enable !== want.write_enable)
               report_mismatch("write_enable", 32'(rsp_payload.write_enable),
                               32'(want.write_enable));
            if (rsp_payload.byte_address !== want.byte_address)
               report_mismatch("byte_address", rsp_payload.byte_address, want.byte_address);
            if (rsp_payload.write_data !== want.write_data)
               report_mismatch("write_data", rsp_payload.write_data, want.write_data);
            if (rsp_payload.write_size !== want.write_size)
               report_mismatch("write_size", 32'(rsp_payload.write_size),
                               32'(want.write_size));
            if (rsp_payload.bit_mask !== want.bit_mask)
               report_mismatch("bit_mask", 32'(rsp_payload.bit_mask), 32'(want.bit_mask));
            if (rsp_payload.flush_done !== want.flush_done)
               report_mismatch("flush_done", 32'(rsp_payload.flush_done),
                               32'(want.flush_done));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats pending", cycle_count,
                  expected_writes.size());
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_pixel_modes();
      test_reject_cases();
      test_rotated_clip();
      test_abandoned_rect();
      test_random_traffic();
      settle();
      repeat (8) @(posedge clock);
      if (expected_writes.size() != 0)
         report_mismatch("beats never seen", 32'(expected_writes.size()), 32'd0);
      $display("covered %0d items, %0d result beats and %0d register writes", items_taken,
               beats_seen, csr_writes);
      $display("all pixel modes, rejects, clipping, rotation swap and dropped rectangles");
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[clipped_rect_pixel_writer_top.f]
design/crpw_pkg.sv
design/crpw_csr.sv
design/crpw_in_stage.sv
design/crpw_engine.sv
design/clipped_rect_pixel_writer_top.sv
dv/tb_clipped_rect_pixel_writer_top.sv
